FILE: hw/rtl/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
// Used by the front classifier, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package b64d_pkg;

    // Character codes of interest
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;
    localparam logic [7:0] CHR_PAD     = 8'h3D;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_TAB     = 8'h09;

    // Sextet offsets of the alphabet ranges
    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_PAD,
        CLS_DATA,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  sextet;
        logic        last;
    } b64d_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: hw/rtl/base64_stream_decoder.sv
// Base64 stream decoder, one character request per cycle while char_stall is low.
// An accepted character is written into the queue; the back end then decodes the
// queue head and loads the result register.
// One character per cycle while neither side stalls; a stalled result holds the back
// end and the input stalls once both queue slots fill.
// Reset (rst_n low, asynchronous) empties the queue, clears residue and stop flag.
`timescale 1ns / 1ps

module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] byte_out,
    output logic       byte_valid,
    output logic       bad_char,
    output logic       string_done
);
    import b64d_pkg::*;

    logic          push;
    logic          pop;
    b64d_item_t    push_item;
    b64d_item_t    head_item;
    queue_status_t q_status;

    b64d_front u_front (
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_in       (char_in),
        .end_of_string (end_of_string),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .byte_out     (byte_out),
        .byte_valid   (byte_valid),
        .bad_char     (bad_char),
        .string_done  (string_done)
    );

    // A bad character never carries a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(bad_char && byte_valid))
        else $error("result flags both a byte and a bad character");

    // Queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // Never pop an empty queue or push a full one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty) && !(push && q_status.full))
        else $error("queue overrun or underrun");

endmodule

FILE: hw/rtl/b64d_front.sv
// Front end: takes requests from the character channel and classifies them.
// Depends on b64d_pkg; feeds b64d_queue.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                   char_valid,
    output logic                   char_stall,
    input  logic [7:0]             char_in,
    input  logic                   end_of_string,
    input  b64d_pkg::queue_status_t q_status,
    output logic                   push,
    output b64d_pkg::b64d_item_t   push_item
);
    import b64d_pkg::*;

    logic [7:0] offset;

    // Hold requests off while the queue is full
    assign char_stall = q_status.full;
    assign push       = char_valid && !q_status.full;

    // Classify the character and derive its sextet
    always_comb
    begin
        offset           = 8'd0;
        push_item.cls    = CLS_BAD;
        push_item.sextet = 6'd0;
        push_item.last   = end_of_string;
        case (char_in) inside
            [CHR_UPPER_A:CHR_UPPER_Z]:
            begin
                offset           = char_in - CHR_UPPER_A;
                push_item.cls    = CLS_DATA;
                push_item.sextet = offset[5:0];
            end
            [CHR_LOWER_A:CHR_LOWER_Z]:
            begin
                offset           = char_in - CHR_LOWER_A;
                push_item.cls    = CLS_DATA;
                push_item.sextet = offset[5:0] + SEXTET_LOWER_BASE;
            end
            [CHR_DIGIT_0:CHR_DIGIT_9]:
            begin
                offset           = char_in - CHR_DIGIT_0;
                push_item.cls    = CLS_DATA;
                push_item.sextet = offset[5:0] + SEXTET_DIGIT_BASE;
            end
            CHR_PLUS:
            begin
                push_item.cls    = CLS_DATA;
                push_item.sextet = SEXTET_PLUS;
            end
            CHR_SLASH:
            begin
                push_item.cls    = CLS_DATA;
                push_item.sextet = SEXTET_SLASH;
            end
            CHR_PAD:
            begin
                push_item.cls = CLS_PAD;
            end
            CHR_CR, CHR_LF, CHR_SPACE, CHR_TAB:
            begin
                push_item.cls = CLS_SPACE;
            end
            default:
            begin
                push_item.cls = CLS_BAD;
            end
        endcase
    end

endmodule

FILE: hw/rtl/b64d_queue.sv
// Short queue of classified characters between front and back end.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  b64d_pkg::b64d_item_t    push_item,
    input  logic                    pop,
    output b64d_pkg::b64d_item_t    head_item,
    output b64d_pkg::queue_status_t q_status
);
    import b64d_pkg::*;

    b64d_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    // Status comes straight from the count register
    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_item      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/b64d_back.sv
// Back end: keeps the bit residue and stop flag, packs sextets into bytes
// and holds the result register. Depends on b64d_pkg; reads from b64d_queue.
`timescale 1ns / 1ps

module b64d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64d_pkg::b64d_item_t    head_item,
    input  b64d_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [7:0]              byte_out,
    output logic                    byte_valid,
    output logic                    bad_char,
    output logic                    string_done
);
    import b64d_pkg::*;

    logic [5:0]  residue_reg, residue_next;
    logic [1:0]  pairs_reg, pairs_next;
    logic        stopped_reg, stopped_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic        bad_reg, bad_next;
    logic        done_reg, done_next;

    logic        out_free;
    logic        have_byte;
    logic        bad;
    logic [7:0]  byte_val;
    logic [11:0] acc;
    logic [11:0] acc_shift;
    logic [2:0]  rest;
    logic [5:0]  rest_mask;
    logic        produce;

    // Pop whenever the queue holds an item and the result register can take a new value
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = !q_status.empty && out_free;

    assign acc       = {residue_reg, head_item.sextet};
    assign rest      = {pairs_reg - 2'd1, 1'b0};
    assign acc_shift = acc >> rest;
    assign rest_mask = 6'((7'd1 << rest) - 7'd1);

    // Decode one character against the residue
    always_comb
    begin
        residue_next = residue_reg;
        pairs_next   = pairs_reg;
        stopped_next = stopped_reg;
        have_byte    = 1'b0;
        bad          = 1'b0;
        byte_val     = 8'd0;
        if (pop)
        begin
            if (!stopped_reg)
            begin
                case (head_item.cls)
                    CLS_PAD:
                    begin
                        stopped_next = 1'b1;
                    end
                    CLS_BAD:
                    begin
                        bad          = 1'b1;
                        stopped_next = 1'b1;
                    end
                    CLS_DATA:
                    begin
                        if (pairs_reg == 2'd0)
                        begin
                            residue_next = head_item.sextet;
                            pairs_next   = 2'd3;
                        end
                        else
                        begin
                            have_byte    = 1'b1;
                            byte_val     = acc_shift[7:0];
                            residue_next = acc[5:0] & rest_mask;
                            pairs_next   = pairs_reg - 2'd1;
                        end
                    end
                    default:
                    begin
                        // whitespace: skip
                    end
                endcase
            end
            // Clear the residue, pair count and stop flag at the end of the string
            if (head_item.last)
            begin
                residue_next = 6'd0;
                pairs_next   = 2'd0;
                stopped_next = 1'b0;
            end
        end
    end

    assign produce = pop && (have_byte || bad || head_item.last);

    // Load or drop the result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        byte_valid_next = byte_valid_reg;
        bad_next        = bad_reg;
        done_next       = done_reg;
        if (out_free)
        begin
            out_valid_next = produce;
            if (produce)
            begin
                byte_next       = byte_val;
                byte_valid_next = have_byte;
                bad_next        = bad;
                done_next       = head_item.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_reg   <= 6'd0;
            pairs_reg     <= 2'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            residue_reg   <= residue_next;
            pairs_reg     <= pairs_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        byte_valid_reg <= byte_valid_next;
        bad_reg        <= bad_next;
        done_reg       <= done_next;
    end

    assign result_valid = out_valid_reg;
    assign byte_out     = byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign bad_char     = bad_reg;
    assign string_done  = done_reg;

endmodule
